>>> sv/sbd_pkg.sv
// ----------------------------------------------------------------------------
// sbd_pkg: scaler bank decoder shared definitions
// Status codes, register indexes, header constants and payload word layout.
// ----------------------------------------------------------------------------
package sbd_pkg;

    typedef enum logic [1:0] {
        STATUS_OK            = 2'd0,
        STATUS_DISABLED      = 2'd1,
        STATUS_NO_PAYLOAD    = 2'd2,
        STATUS_SLOT_MISMATCH = 2'd3
    } status_t;

    // register indexes on the config port
    localparam logic [1:0] CFG_ENABLE  = 2'd0;
    localparam logic [1:0] CFG_SLOT    = 2'd1;
    localparam logic [1:0] CFG_SOURCE  = 2'd2;
    localparam logic [1:0] CFG_CHANNEL = 2'd3;

    // counter source codes
    localparam logic [1:0] SRC_REF  = 2'd0;
    localparam logic [1:0] SRC_TRIG = 2'd1;
    localparam logic [1:0] SRC_TDC  = 2'd2;

    localparam int PAYLOAD_WORDS = 67;
    localparam int CHANNELS      = 16;
    localparam int IDX_W         = 7;

    localparam logic [31:0] HDR_MASK   = 32'hFFFF_0000;
    localparam logic [31:0] HDR_MAGIC  = 32'hDCA0_0000;
    localparam logic [4:0]  BLOCK_TYPE = 5'h10;

    // word positions relative to the payload header
    localparam logic [IDX_W-1:0] REL_TRIG_GATED   = 7'd1;
    localparam logic [IDX_W-1:0] REL_TDC_GATED    = 7'(1 + CHANNELS);
    localparam logic [IDX_W-1:0] REL_TRIG_UNGATED = 7'(1 + 2 * CHANNELS);
    localparam logic [IDX_W-1:0] REL_TDC_UNGATED  = 7'(1 + 3 * CHANNELS);
    localparam logic [IDX_W-1:0] REL_REF_GATED    = 7'(PAYLOAD_WORDS - 2);
    localparam logic [IDX_W-1:0] REL_REF_UNGATED  = 7'(PAYLOAD_WORDS - 1);
    localparam logic [IDX_W-1:0] IDX_MAX          = 7'h7F;

endpackage

>>> sv/scaler_bank_decoder_core.sv
// ----------------------------------------------------------------------------
// scaler_bank_decoder_core: scaler bank header and counter decoder
// Follows two candidate payload starts through a word stream and reports the
// selected counter pair of the first sane payload at the end of each bank.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  -------  ---------  -------------------  -----------------------------------
//  cfg      in         cfg_write            cfg_index, cfg_data
//  in       in         in_valid / in_stall  bank_word, last_word
//  out      out        out_valid/out_stall  status, found_slot, payload_offset,
//                                           gated_count, ungated_count
//
//  One word request per cycle sustained. A word sits in the input register
//  until it moves on, then updates the probe state; a last word loads the result
//  register in that same cycle, and out_valid comes from the result register.
//  Reset clears config, bank state and both valid flags.
//  in_stall rises only when a last word is held while an earlier result is
//  still stalled in the output register; ordinary words never wait.
//
module scaler_bank_decoder_core #(
    parameter int SECOND_PROBE_OFFSET = 2   // 1..7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [1:0]       cfg_index,
    input  logic [7:0]       cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [31:0]      bank_word,
    input  logic             last_word,
    output logic             out_valid,
    input  logic             out_stall,
    output sbd_pkg::status_t status,
    output logic [7:0]       found_slot,
    output logic [2:0]       payload_offset,
    output logic [31:0]      gated_count,
    output logic [31:0]      ungated_count
);
    import sbd_pkg::*;

    // probe 0 starts at word 0, probe 1 at the second offset
    localparam logic [1:0][IDX_W-1:0] START = {7'(SECOND_PROBE_OFFSET), 7'd0};
    localparam logic [1:0][2:0] START_OUT = {3'(SECOND_PROBE_OFFSET), 3'd0};

    // config registers
    logic       enable_reg;
    logic [7:0] wanted_slot_reg;
    logic [1:0] source_reg;
    logic [3:0] channel_reg;

    // input register
    logic        in_v_reg;
    logic [31:0] word_reg;
    logic        last_reg;

    // bank state
    logic [IDX_W-1:0] word_idx_reg,  word_idx_next;
    logic [31:0]      first_word_reg, first_word_next;
    logic [1:0]       hdr_ok_reg,    hdr_ok_next;
    logic [7:0]       slot_reg   [2];
    logic [7:0]       slot_next  [2];
    logic [31:0]      ref_g_reg  [2];
    logic [31:0]      ref_g_next [2];
    logic [31:0]      ref_u_reg  [2];
    logic [31:0]      ref_u_next [2];
    logic [31:0]      sel_g_reg  [2];
    logic [31:0]      sel_g_next [2];
    logic [31:0]      sel_u_reg  [2];
    logic [31:0]      sel_u_next [2];

    // result register
    logic        out_v_reg;
    status_t     status_reg,   status_next;
    logic [7:0]  fslot_reg,    fslot_next;
    logic [2:0]  offset_reg,   offset_next;
    logic [31:0] gcount_reg,   gcount_next;
    logic [31:0] ucount_reg,   ucount_next;

    logic             advance;
    logic             finish;
    logic             in_take;
    logic [IDX_W-1:0] gsel;
    logic [IDX_W-1:0] usel;
    logic [IDX_W-1:0] rel   [2];
    logic [1:0]       sane;

    // a held word moves on unless it is a last word blocked by a waiting result
    assign advance  = in_v_reg && (!last_reg || !out_v_reg || !out_stall);
    assign finish   = advance && last_reg;
    assign in_stall = in_v_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // counter positions picked by the source and channel registers
    always_comb
    begin
        case (source_reg)
            SRC_TRIG:
            begin
                gsel = REL_TRIG_GATED + {3'd0, channel_reg};
                usel = REL_TRIG_UNGATED + {3'd0, channel_reg};
            end
            SRC_TDC:
            begin
                gsel = REL_TDC_GATED + {3'd0, channel_reg};
                usel = REL_TDC_UNGATED + {3'd0, channel_reg};
            end
            default:
            begin
                gsel = REL_REF_GATED;
                usel = REL_REF_UNGATED;
            end
        endcase
    end

    // per-probe capture of header, references and selected counters
    always_comb
    begin
        first_word_next = (word_idx_reg == '0) ? word_reg : first_word_reg;
        word_idx_next   = (word_idx_reg == IDX_MAX) ? word_idx_reg : word_idx_reg + 7'd1;
        for (int k = 0; k < 2; k++)
        begin
            hdr_ok_next[k] = hdr_ok_reg[k];
            slot_next[k]   = slot_reg[k];
            ref_g_next[k]  = ref_g_reg[k];
            ref_u_next[k]  = ref_u_reg[k];
            sel_g_next[k]  = sel_g_reg[k];
            sel_u_next[k]  = sel_u_reg[k];
            rel[k]         = word_idx_reg - START[k];
            if (word_idx_reg >= START[k])
            begin
                if (rel[k] == '0)
                begin
                    if ((word_reg & HDR_MASK) == HDR_MAGIC)
                    begin
                        hdr_ok_next[k] = 1'b1;
                        slot_next[k]   = word_reg[15:8];
                    end
                    else if (START[k] != '0 && first_word_reg[31:27] == BLOCK_TYPE)
                    begin
                        // block header in word 0 carries a 5-bit slot
                        hdr_ok_next[k] = 1'b1;
                        slot_next[k]   = {3'd0, first_word_reg[26:22]};
                    end
                end
                else
                begin
                    if (rel[k] == REL_REF_GATED)
                        ref_g_next[k] = word_reg;
                    if (rel[k] == REL_REF_UNGATED)
                        ref_u_next[k] = word_reg;
                    if (rel[k] == gsel)
                        sel_g_next[k] = word_reg;
                    if (rel[k] == usel)
                        sel_u_next[k] = word_reg;
                end
            end
        end
    end

    // winner pick on the state as updated by the current word
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            sane[k] = hdr_ok_next[k]
                   && (word_idx_reg >= START[k] + REL_REF_UNGATED)
                   && (ref_u_next[k] != '0)
                   && (ref_u_next[k] >= ref_g_next[k]);
        end
        status_next = STATUS_OK;
        fslot_next  = '0;
        offset_next = '0;
        gcount_next = '0;
        ucount_next = '0;
        if (!enable_reg)
            status_next = STATUS_DISABLED;
        else if (sane == 2'b00)
            status_next = STATUS_NO_PAYLOAD;
        else if (sane[0])
        begin
            fslot_next  = slot_next[0];
            offset_next = START_OUT[0];
            if (slot_next[0] != wanted_slot_reg)
                status_next = STATUS_SLOT_MISMATCH;
            else
            begin
                gcount_next = sel_g_next[0];
                ucount_next = sel_u_next[0];
            end
        end
        else
        begin
            fslot_next  = slot_next[1];
            offset_next = START_OUT[1];
            if (slot_next[1] != wanted_slot_reg)
                status_next = STATUS_SLOT_MISMATCH;
            else
            begin
                gcount_next = sel_g_next[1];
                ucount_next = sel_u_next[1];
            end
        end
    end

    // control and bank state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b0;
            wanted_slot_reg <= '0;
            source_reg      <= SRC_REF;
            channel_reg     <= '0;
            in_v_reg        <= 1'b0;
            out_v_reg       <= 1'b0;
            word_idx_reg    <= '0;
            first_word_reg  <= '0;
            hdr_ok_reg      <= '0;
            for (int k = 0; k < 2; k++)
            begin
                slot_reg[k]  <= '0;
                ref_g_reg[k] <= '0;
                ref_u_reg[k] <= '0;
                sel_g_reg[k] <= '0;
                sel_u_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_ENABLE:  enable_reg      <= cfg_data[0];
                    CFG_SLOT:    wanted_slot_reg <= cfg_data;
                    CFG_SOURCE:  source_reg      <= cfg_data[1:0];
                    CFG_CHANNEL: channel_reg     <= cfg_data[3:0];
                    default:     enable_reg      <= enable_reg;
                endcase
            end
            if (in_take)
                in_v_reg <= 1'b1;
            else if (advance)
                in_v_reg <= 1'b0;
            if (finish)
                out_v_reg <= 1'b1;
            else if (!out_stall)
                out_v_reg <= 1'b0;
            if (advance)
            begin
                // last word closes the bank
                word_idx_reg   <= last_reg ? '0 : word_idx_next;
                first_word_reg <= last_reg ? '0 : first_word_next;
                hdr_ok_reg     <= last_reg ? '0 : hdr_ok_next;
                for (int k = 0; k < 2; k++)
                begin
                    slot_reg[k]  <= last_reg ? '0 : slot_next[k];
                    ref_g_reg[k] <= last_reg ? '0 : ref_g_next[k];
                    ref_u_reg[k] <= last_reg ? '0 : ref_u_next[k];
                    sel_g_reg[k] <= last_reg ? '0 : sel_g_next[k];
                    sel_u_reg[k] <= last_reg ? '0 : sel_u_next[k];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            word_reg <= bank_word;
            last_reg <= last_word;
        end
        if (finish)
        begin
            status_reg <= status_next;
            fslot_reg  <= fslot_next;
            offset_reg <= offset_next;
            gcount_reg <= gcount_next;
            ucount_reg <= ucount_next;
        end
    end

    assign out_valid      = out_v_reg;
    assign status         = status_reg;
    assign found_slot     = fslot_reg;
    assign payload_offset = offset_reg;
    assign gated_count    = gcount_reg;
    assign ungated_count  = ucount_reg;

    // stall only ever holds a pending word
    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_v_reg && last_reg && out_v_reg))
        else $error("input stalled without a blocked last word");

    // bank state restarts after every last word
    a_bank_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (word_idx_reg == '0 && hdr_ok_reg == 2'b00 && out_v_reg))
        else $error("bank state not cleared after last word");

    // counts only leave on a good result
    a_counts_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && status_reg != STATUS_OK) |-> (gcount_reg == '0 && ucount_reg == '0))
        else $error("nonzero counts on an error result");

    // no winner means no slot and no offset
    a_no_winner: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && (status_reg == STATUS_DISABLED || status_reg == STATUS_NO_PAYLOAD))
        |-> (fslot_reg == '0 && offset_reg == '0))
        else $error("slot or offset reported without a winner");

endmodule

>>> verif/scaler_bank_decoder_core_tb.sv
// ----------------------------------------------------------------------------
// scaler_bank_decoder_core_tb: self-checking bench for the scaler bank decoder
// Streams banks of words through the decoder and predicts one report per bank
// from the header, slot, length and reference checks. Every report is matched
// field by field, in order. Config changes between phases, sometimes mid-bank.
// ----------------------------------------------------------------------------
module scaler_bank_decoder_core_tb;

    import sbd_pkg::*;

    localparam int PROBE2      = 2;        // second candidate payload start
    localparam int CYCLE_LIMIT = 200000;   // generous watchdog bound for a correct run
    localparam int HOLD_CYCLES = 300;      // long receiver hold-off
    localparam int RANDOM_WORDS = 1350;
    localparam logic [1:0] SRC_UNUSED = 2'd3;  // spare source code, acts as ref pair

    typedef struct packed {
        status_t     status;
        logic [7:0]  slot;
        logic [2:0]  offset;
        logic [31:0] gated;
        logic [31:0] ungated;
    } bank_report_t;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } bank_item_t;

    typedef enum int {BK_LEGACY, BK_SECOND, BK_BOTH, BK_SHORT, BK_NOISE} bank_kind_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports
    // ------------------------------------------------------------------
    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = CFG_ENABLE;
    logic [7:0]  cfg_data  = 8'h00;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [31:0] bank_word = 32'h0;
    logic        last_word = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    status_t     status;
    logic [7:0]  found_slot;
    logic [2:0]  payload_offset;
    logic [31:0] gated_count;
    logic [31:0] ungated_count;

    scaler_bank_decoder_core #(
        .SECOND_PROBE_OFFSET (PROBE2)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .bank_word      (bank_word),
        .last_word      (last_word),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .found_slot     (found_slot),
        .payload_offset (payload_offset),
        .gated_count    (gated_count),
        .ungated_count  (ungated_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    bank_item_t   word_queue[$];        // words waiting for the driver
    bank_item_t   carry_words[$];       // tail of a bank split across phases
    bank_report_t pending_reports[$];   // predicted reports, oldest first

    int words_queued   = 0;
    int words_accepted = 0;
    int random_words   = 0;
    int banks_queued   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors         = 0;
    int reports_seen   = 0;
    int input_stalls   = 0;
    int cycle_count    = 0;
    int status_seen [4] = '{0, 0, 0, 0};

    // pressure: main sequence raises the request, stall process owns the count
    bit pressure_go = 1'b0;
    bit hold_done   = 1'b0;
    int hold_left   = 0;

    // predictor copy of the config registers (reset values)
    logic       m_enable  = 1'b0;
    logic [7:0] m_slot    = 8'h00;
    logic [1:0] m_source  = SRC_REF;
    logic [3:0] m_channel = 4'h0;

    // predictor copy of the per-bank tracking state
    logic [6:0]  trk_index = 7'd0;
    logic [31:0] trk_first = 32'h0;
    logic        hdr_ok   [2] = '{1'b0, 1'b0};
    logic [7:0]  hdr_slot [2] = '{8'h0, 8'h0};
    logic [31:0] ref_g    [2] = '{32'h0, 32'h0};
    logic [31:0] ref_u    [2] = '{32'h0, 32'h0};
    logic [31:0] sel_g    [2] = '{32'h0, 32'h0};
    logic [31:0] sel_u    [2] = '{32'h0, 32'h0};

    // ------------------------------------------------------------------
    // Predictor: one accepted word in, a report queued on the last word.
    // Config is the value in force when the word is taken.
    // ------------------------------------------------------------------
    function automatic void decode_word(input logic [31:0] w, input logic last);
        int idx, rel, start, gsel, usel, win, k;
        bank_report_t rep;
        idx = int'(trk_index);
        if (idx == 0)
            trk_first = w;
        for (k = 0; k < 2; k++)
        begin
            start = (k == 0) ? 0 : PROBE2;
            if (idx >= start)
            begin
                rel = idx - start;
                if (rel == 0)
                begin
                    // legacy magic header, or block header in word 0 for the later start
                    if ((w & HDR_MASK) == HDR_MAGIC)
                    begin
                        hdr_ok[k]   = 1'b1;
                        hdr_slot[k] = w[15:8];
                    end
                    else if (start >= 1 && trk_first[31:27] == BLOCK_TYPE)
                    begin
                        hdr_ok[k]   = 1'b1;
                        hdr_slot[k] = {3'b000, trk_first[26:22]};
                    end
                end
                else
                begin
                    if (rel == PAYLOAD_WORDS - 2)
                        ref_g[k] = w;
                    if (rel == PAYLOAD_WORDS - 1)
                        ref_u[k] = w;
                    case (m_source)
                        SRC_TRIG:
                        begin
                            gsel = 1 + int'(m_channel);
                            usel = 1 + 2 * CHANNELS + int'(m_channel);
                        end
                        SRC_TDC:
                        begin
                            gsel = 1 + CHANNELS + int'(m_channel);
                            usel = 1 + 3 * CHANNELS + int'(m_channel);
                        end
                        default:
                        begin
                            gsel = PAYLOAD_WORDS - 2;
                            usel = PAYLOAD_WORDS - 1;
                        end
                    endcase
                    if (rel == gsel)
                        sel_g[k] = w;
                    if (rel == usel)
                        sel_u[k] = w;
                end
            end
        end
        if (trk_index != IDX_MAX)
            trk_index = trk_index + 7'd1;
        if (!last)
            return;

        // first sane candidate wins, offset 0 ahead of the second start
        win = -1;
        for (k = 0; k < 2 && win < 0; k++)
        begin
            start = (k == 0) ? 0 : PROBE2;
            if (hdr_ok[k] && idx + 1 >= start + PAYLOAD_WORDS && ref_u[k] != 0 &&
                ref_u[k] >= ref_g[k])
                win = k;
        end

        rep = '0;
        if (!m_enable)
            rep.status = STATUS_DISABLED;
        else if (win < 0)
            rep.status = STATUS_NO_PAYLOAD;
        else
        begin
            rep.slot   = hdr_slot[win];
            rep.offset = (win == 0) ? 3'd0 : 3'(PROBE2);
            if (hdr_slot[win] != m_slot)
                rep.status = STATUS_SLOT_MISMATCH;
            else
            begin
                rep.status  = STATUS_OK;
                rep.gated   = sel_g[win];
                rep.ungated = sel_u[win];
            end
        end
        pending_reports.push_back(rep);

        // bank done: start clean for the next one
        trk_index = 7'd0;
        trk_first = 32'h0;
        for (k = 0; k < 2; k++)
        begin
            hdr_ok[k]   = 1'b0;
            hdr_slot[k] = 8'h0;
            ref_g[k]    = 32'h0;
            ref_u[k]    = 32'h0;
            sel_g[k]    = 32'h0;
            sel_u[k]    = 32'h0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued words, holds a stalled request steady,
    // idles at random between requests.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        bank_item_t nxt;
        if (rst_n)
        begin
            if (in_valid && in_stall)
                input_stalls++;
            if (in_valid && !in_stall)
            begin
                decode_word(bank_word, last_word);
                words_accepted++;
            end
            // slot is free once the current request is gone
            if (!in_valid || !in_stall)
            begin
                if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = word_queue.pop_front();
                    bank_word <= nxt.word;
                    last_word <= nxt.last;
                    in_valid  <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure: random stalls, plus one long hold-off that
    // lets the result register fill and back up into the input.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else if (pressure_go && !hold_done)
        begin
            out_stall <= 1'b1;
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Checker: each taken report against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        bank_report_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{status, found_slot, payload_offset, gated_count, ungated_count};
            reports_seen++;
            status_seen[int'(status)]++;
            if (pending_reports.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("[%0d] unexpected report: status=%s slot=%0d off=%0d",
                             cycle_count, got.status.name(), got.slot, got.offset);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("[%0d] report mismatch: expected %s slot=%0d off=%0d gated=%h ungated=%h",
                                 cycle_count, want.status.name(), want.slot, want.offset,
                                 want.gated, want.ungated);
                        $display("[%0d]                  actual   %s slot=%0d off=%0d gated=%h ungated=%h",
                                 cycle_count, got.status.name(), got.slot, got.offset,
                                 got.gated, got.ungated);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, pending_reports.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_word(input logic [31:0] w, input logic last);
        word_queue.push_back('{w, last});
        words_queued++;
    endtask

    task automatic push_carry();
        while (carry_words.size() != 0)
        begin
            word_queue.push_back(carry_words.pop_front());
            words_queued++;
        end
    endtask

    // all accepted, all reports out, then let words still in the pipe settle
    task automatic wait_drained();
        while (words_accepted != words_queued || pending_reports.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_config(input logic en, input logic [7:0] slot,
                                input logic [1:0] src, input logic [3:0] ch);
        logic [7:0] vals [4];
        vals[CFG_ENABLE]  = {7'b0, en};
        vals[CFG_SLOT]    = slot;
        vals[CFG_SOURCE]  = {6'b0, src};
        vals[CFG_CHANNEL] = {4'b0, ch};
        for (int i = 0; i < 4; i++)
        begin
            @(posedge clk);
            cfg_write <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data  <= vals[i];
        end
        @(posedge clk);
        cfg_write <= 1'b0;
        m_enable  = en;
        m_slot    = slot;
        m_source  = src;
        m_channel = ch;
    endtask

    // half the headers carry the wanted slot
    function automatic logic [31:0] magic_header();
        logic [7:0] s;
        s = $urandom_range(1) ? m_slot : 8'($urandom);
        return HDR_MAGIC | {16'h0, s, 8'($urandom)};
    endfunction

    function automatic logic [31:0] block_header();
        logic [4:0] s;
        s = $urandom_range(1) ? m_slot[4:0] : 5'($urandom);
        return {BLOCK_TYPE, s, 22'($urandom)};
    endfunction

    // {ungated, gated}: mostly sane, sometimes zero, equal or inverted
    function automatic logic [63:0] ref_pair();
        logic [31:0] u, g;
        logic [63:0] prod;
        int pick;
        pick = $urandom_range(9);
        u = $urandom;
        g = $urandom;
        if (pick == 0)
            u = 32'h0;
        else if (pick == 1)
        begin
            if (u == 0)
                u = 32'h1;
            g = u;
        end
        else if (pick >= 3)
        begin
            if (u == 0)
                u = 32'h1;
            prod = 64'(g) * 64'(u);
            g = prod[63:32];
        end
        return {u, g};
    endfunction

    function automatic bank_kind_t pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return BK_LEGACY;
        if (r < 55)
            return BK_SECOND;
        if (r < 70)
            return BK_BOTH;
        if (r < 85)
            return BK_SHORT;
        return BK_NOISE;
    endfunction

    // Build one bank. With split set, only a head goes out now and the rest
    // waits for the next phase, so config changes land mid-bank.
    task automatic queue_bank(input bank_kind_t kind, input bit split, input bit stretch);
        int n, extra, cut;
        logic [31:0] body [];
        logic [63:0] pair;
        extra = (stretch || $urandom_range(19) == 0) ? $urandom_range(60, 70)
                                                      : $urandom_range(0, 3);
        case (kind)
            BK_LEGACY: n = PAYLOAD_WORDS + extra;
            BK_SECOND,
            BK_BOTH:   n = PROBE2 + PAYLOAD_WORDS + extra;
            BK_SHORT:  n = ($urandom_range(3) == 0) ? PROBE2 + PAYLOAD_WORDS - 1
                                                    : $urandom_range(1, PAYLOAD_WORDS - 1);
            default:   n = $urandom_range(1, 8);
        endcase
        body = new[n];
        foreach (body[i])
        begin
            body[i] = $urandom;
            if (kind == BK_NOISE && $urandom_range(3) == 0)
                body[i] = $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
        end
        case (kind)
            BK_LEGACY:
            begin
                body[0] = magic_header();
                pair = ref_pair();
                body[PAYLOAD_WORDS - 2] = pair[31:0];
                body[PAYLOAD_WORDS - 1] = pair[63:32];
            end
            BK_SECOND:
            begin
                if ($urandom_range(1))
                    body[0] = block_header();
                else
                    body[PROBE2] = magic_header();
                pair = ref_pair();
                body[PROBE2 + PAYLOAD_WORDS - 2] = pair[31:0];
                body[PROBE2 + PAYLOAD_WORDS - 1] = pair[63:32];
            end
            BK_BOTH:
            begin
                // first candidate often loses on a dead ungated reference
                body[0] = magic_header();
                body[PROBE2] = magic_header();
                pair = ref_pair();
                if ($urandom_range(1))
                    pair[63:32] = 32'h0;
                body[PAYLOAD_WORDS - 2] = pair[31:0];
                body[PAYLOAD_WORDS - 1] = pair[63:32];
                pair = ref_pair();
                body[PROBE2 + PAYLOAD_WORDS - 2] = pair[31:0];
                body[PROBE2 + PAYLOAD_WORDS - 1] = pair[63:32];
            end
            BK_SHORT:
            begin
                // one word short of the second payload needs a block header
                if (n == PROBE2 + PAYLOAD_WORDS - 1 || $urandom_range(1))
                    body[0] = block_header();
                else
                    body[0] = magic_header();
            end
            default: ;
        endcase
        cut = (split && n > 1) ? $urandom_range(1, n - 1) : n;
        for (int i = 0; i < n; i++)
        begin
            if (i < cut)
                push_word(body[i], i == n - 1);
            else
                carry_words.push_back('{body[i], i == n - 1});
        end
        // every word of the bank counts toward the item budget
        random_words += n;
        banks_queued++;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int seg, seg_end;
        bit pressure_sent;
        seg = 0;
        pressure_sent = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct  = 36;
        recv_stall_pct = 60;

        // Directed: decoder comes out of reset disabled
        push_word(32'hFFFF_FFFF, 1'b1);
        push_word(32'hDCA0_0000, 1'b0);
        push_word(32'h0000_0000, 1'b1);
        wait_drained();

        write_config(1'b1, 8'hFF, SRC_TDC, 4'hF);
        // lone zero word, no payload
        push_word(32'h0000_0000, 1'b1);
        // legacy header with slot 255, bank far too short
        push_word(32'hDCA0_FF00, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word(32'hDCA0_FFFF, 1'b1);
        // block header with top slot, plus a magic word at the second start
        push_word({BLOCK_TYPE, 5'h1F, 22'h0}, 1'b0);
        push_word(32'h8000_0000, 1'b0);
        push_word(32'hDCA0_FF00, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b1);
        // alternating bit patterns
        for (int i = 0; i < 10; i++)
            push_word(i[0] ? 32'h5555_5555 : 32'hAAAA_AAAA, i == 9);

        // Random phases: receiver-heavy stalling, then sender-heavy idling, then none
        while (random_words < RANDOM_WORDS)
        begin
            wait_drained();
            if (random_words < RANDOM_WORDS / 3)
            begin
                send_idle_pct  = 36;
                recv_stall_pct = 60;
            end
            else if (random_words < 2 * RANDOM_WORDS / 3)
            begin
                send_idle_pct  = 60;
                recv_stall_pct = 36;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end

            // first phases pin the register extremes, later ones roam
            case (seg)
                0: write_config(1'b1, 8'h00, SRC_REF, 4'h0);
                1: write_config(1'b1, 8'hFF, SRC_TRIG, 4'hF);
                2: write_config(1'b1, 8'($urandom_range(31)), SRC_TDC, 4'($urandom));
                3: write_config(1'b1, 8'($urandom_range(31)), SRC_UNUSED, 4'($urandom));
                4: write_config(1'b0, 8'($urandom), 2'($urandom), 4'($urandom));
                default:
                    write_config($urandom_range(7) != 0,
                                 $urandom_range(3) == 0 ? 8'($urandom)
                                                        : 8'($urandom_range(31)),
                                 2'($urandom), 4'($urandom));
            endcase
            push_carry();

            // one long receiver hold-off while short banks keep coming
            if (send_idle_pct == 0 && !pressure_sent)
            begin
                pressure_go   = 1'b1;
                pressure_sent = 1'b1;
                repeat (60) queue_bank(BK_NOISE, 1'b0, 1'b0);
            end

            // a bank long enough to saturate the word index
            if (seg == 0)
                queue_bank(BK_LEGACY, 1'b0, 1'b1);
            seg_end = random_words + 150;
            while (random_words < seg_end && random_words < RANDOM_WORDS)
                queue_bank(pick_kind(), 1'b0, 1'b0);
            if ($urandom_range(1))
                queue_bank(pick_kind(), 1'b1, 1'b0);
            seg++;
        end
        push_carry();

        wait_drained();
        repeat (10) @(posedge clk);

        $display("Covered %0d words in %0d random banks over %0d config phases, %0d reports.",
                 words_accepted, banks_queued, seg, reports_seen);
        $display("Status ok %0d, disabled %0d, no payload %0d, slot mismatch %0d; %0d input stalls.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3], input_stalls);
        if (errors == 0 && pending_reports.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
